// ----- rtl/eerb_pkg.sv -----
// ----------------------------------------------------------------------------
// eerb_pkg
// Shared types and constants for the epoch event ring buffer: operation
// codes, status codes, field widths and the per-item context that travels
// from the pointer control to the result stage.
// ----------------------------------------------------------------------------
package eerb_pkg;

    // default ring depth in entries
    localparam int DEPTH_DEF = 1024;

    // field widths
    localparam int TS_W     = 64;
    localparam int IDX_W    = 10;
    localparam int DIST_W   = 10;
    localparam int EC_W     = 10;
    localparam int MODE_W   = 3;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 80;

    // operation carried by each input word
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT       = 3'd0,
        MODE_NEW_EPOCH    = 3'd1,
        MODE_READ_ELEMENT = 3'd2,
        MODE_READ_PAST    = 3'd3,
        MODE_CLEAR        = 3'd4
    } t_mode;

    // result status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_DIST = 2'd2
    } t_status;

    // context of one item between the control and the result stage
    typedef struct packed {
        logic            use_mem;      // result data comes from the store
        logic            hit;          // entry has been written since reset
        logic            ones;         // constant result is all ones
        logic            found;
        t_status         status;
        logic [EC_W-1:0] epoch_count;
    } t_meta;

endpackage

// ----- rtl/epoch_event_ring_buffer_top.sv -----
// ----------------------------------------------------------------------------
// epoch_event_ring_buffer_top
// Ring store of 64-bit event time steps grouped into epochs.
//
// Slave channel (s_*): one operation per word; s_tuser carries the mode
// (insert, new epoch, read element, read past, clear), s_tdata the time
// step, epoch index and past distance. Master channel (m_*): one result
// word per operation with read data, found flag, status and epoch count.
// Result path: store read data and context are registered, then loaded
// into the result register when it is free. Throughput: one operation per
// cycle unless the receiver stalls; pointer state updates at the accept
// edge and the single store port serves one read or one write per cycle.
// Reset (synchronous, active low) clears the pointers, the count and the
// fill mark; entries not written since reset read as all ones, so no
// clearing pass over the store is needed and words are taken straight away.
// When the receiver stalls, the result register and one item in the read
// stage are held and s_tready drops until the result register drains.
// ----------------------------------------------------------------------------
module epoch_event_ring_buffer_top import eerb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // time_step[63:0], epoch_index[73:64], past_distance[83:74], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // mode[2:0]
    input  logic [MODE_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // read_data[63:0], found[64], status[66:65], epoch_count[76:67], zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);

    logic                s_accept;
    logic                move;
    logic                mem_wr;
    logic                mem_rd;
    logic [AW-1:0]       mem_addr;
    logic [TS_W-1:0]     mem_rdata;
    t_meta               meta;
    logic [TS_W-1:0]     res_data;

    logic                r_pend, n_pend;
    t_meta               r_meta;
    logic                r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    // handshake
    assign move     = r_pend && (!r_out_valid || m_tready);
    assign s_tready = !r_pend || move;
    assign s_accept = s_tvalid && s_tready;

    // pointer control
    eerb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_accept),
        .i_mode          (t_mode'(s_tuser)),
        .i_epoch_index   (s_tdata[TS_W +: IDX_W]),
        .i_past_distance (s_tdata[TS_W + IDX_W +: DIST_W]),
        .o_mem_wr        (mem_wr),
        .o_mem_rd        (mem_rd),
        .o_mem_addr      (mem_addr),
        .o_meta          (meta)
    );

    // event store
    eerb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_rd    (mem_rd),
        .i_addr  (mem_addr),
        .i_wdata (s_tdata[TS_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // result data selection
    always_comb begin
        if (r_meta.use_mem) begin
            res_data = r_meta.hit ? mem_rdata : '1;
        end else begin
            res_data = r_meta.ones ? '1 : '0;
        end
    end

    // stage occupancy
    always_comb begin
        n_pend      = s_accept ? 1'b1 : (move ? 1'b0 : r_pend);
        n_out_valid = move ? 1'b1 : (m_tready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // item context and result word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_meta <= meta;
        end
        if (move) begin
            r_out_data <= {3'b000, r_meta.epoch_count, r_meta.status,
                           r_meta.found, res_data};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a held item in the read stage stays until it can move on
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !move) |=> r_pend)
        else $error("pending item lost while stalled");

    // no new word is taken while the read stage is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_out_valid && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline blocked");

    // every result word comes from an item that reached the read stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_pend))
        else $error("result shown without a pending item");
`endif

endmodule

// ----- rtl/eerb_store.sv -----
// ----------------------------------------------------------------------------
// eerb_store
// Single-port event store: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module eerb_store import eerb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr,
    input  logic                     i_rd,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [TS_W-1:0]          i_wdata,
    output logic [TS_W-1:0]          o_rdata
);

    logic [TS_W-1:0] r_mem [DEPTH];
    logic [TS_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/eerb_ctrl.sv -----
// ----------------------------------------------------------------------------
// eerb_ctrl
// Pointer control: holds write pointer, epoch start, event count and the
// fill mark, decodes the operation, forms the store address and the
// context for the result stage.
// ----------------------------------------------------------------------------
module eerb_ctrl import eerb_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_mode                    i_mode,
    input  logic [IDX_W-1:0]         i_epoch_index,
    input  logic [DIST_W-1:0]        i_past_distance,
    output logic                     o_mem_wr,
    output logic                     o_mem_rd,
    output logic [$clog2(DEPTH)-1:0] o_mem_addr,
    output t_meta                    o_meta
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = ((AW > EC_W) ? AW : EC_W) + 1;

    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_es, n_es;
    logic [AW-1:0] r_count, n_count;
    // entries below the fill mark have been written since reset
    logic [AW:0]   r_fill, n_fill;

    logic [SW-1:0] count_ext;
    logic [SW-1:0] dist_ext;
    logic [SW-1:0] wp_ext;
    logic [SW-1:0] pos_ext;

    // reduce a narrow sum modulo the depth by conditional subtraction
    function automatic logic [AW-1:0] f_mod_depth(input logic [SW-1:0] v_in);
        int v;
        int k;
        v = int'(v_in);
        for (k = 8; k >= 0; k--) begin
            if ((DEPTH << k) < (1 << SW) && v >= (DEPTH << k)) begin
                v = v - (DEPTH << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // operation decode and next state
    always_comb begin
        n_wp       = r_wp;
        n_es       = r_es;
        n_count    = r_count;
        n_fill     = r_fill;
        o_mem_wr   = 1'b0;
        o_mem_rd   = 1'b0;
        o_mem_addr = r_wp;
        o_meta     = '0;
        dist_ext   = SW'(i_past_distance);
        wp_ext     = SW'(r_wp);
        pos_ext    = (dist_ext > wp_ext) ? (wp_ext + SW'(DEPTH) - dist_ext)
                                         : (wp_ext - dist_ext);
        case (i_mode)
            MODE_INSERT: begin
                if (r_count == AW'(DEPTH - 1)) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_mem_wr = i_accept;
                    n_wp     = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_count  = r_count + 1'b1;
                    if ({1'b0, r_wp} >= r_fill) begin
                        n_fill = {1'b0, r_wp} + 1'b1;
                    end
                end
            end
            MODE_NEW_EPOCH: begin
                n_es    = r_wp;
                n_count = '0;
            end
            MODE_READ_ELEMENT: begin
                o_mem_addr     = f_mod_depth(SW'(r_es) + SW'(i_epoch_index));
                o_mem_rd       = i_accept;
                o_meta.use_mem = 1'b1;
            end
            MODE_READ_PAST: begin
                if (i_past_distance == '0 || int'(i_past_distance) >= DEPTH - 1) begin
                    o_meta.ones   = 1'b1;
                    o_meta.status = ST_BAD_DIST;
                end else if (dist_ext > SW'(r_count)) begin
                    o_meta.ones = 1'b1;
                end else begin
                    o_mem_addr     = pos_ext[AW-1:0];
                    o_mem_rd       = i_accept;
                    o_meta.use_mem = 1'b1;
                    o_meta.found   = 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_wp    = '0;
                n_es    = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        o_meta.hit         = ({1'b0, o_mem_addr} < r_fill);
        count_ext          = SW'(n_count);
        o_meta.epoch_count = count_ext[EC_W-1:0];
    end

    // pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_es    <= '0;
            r_count <= '0;
            r_fill  <= '0;
        end else if (i_accept) begin
            r_wp    <= n_wp;
            r_es    <= n_es;
            r_count <= n_count;
            r_fill  <= n_fill;
        end
    end

`ifndef SYNTHESIS
    // a successful insert advances the count by one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_mode == MODE_INSERT && r_count != AW'(DEPTH - 1))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not advance event count");

    // a new epoch starts at the write pointer with an empty count
    a_new_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_mode == MODE_NEW_EPOCH)
        |=> (r_es == $past(r_wp) && r_count == '0))
        else $error("new epoch not anchored at write pointer");

    // the write pointer never runs ahead of the fill mark
    a_fill_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp} <= r_fill || r_fill == AW'(DEPTH) + 1'b0 || r_fill == (AW + 1)'(DEPTH)))
        else $error("write pointer beyond fill mark");
`endif

endmodule
